>>> sv/tp1fd_pkg.sv
// Shared types and constants for the TP1 frame decoder.
package tp1fd_pkg;

    // Control byte bit masks.
    localparam logic [7:0] CTRL_STANDARD = 8'h80;
    localparam logic [7:0] CTRL_RESERVED = 8'h40;
    localparam logic [7:0] CTRL_REPEAT   = 8'h20;

    // Low nibble of the length field or extension byte.
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;
    localparam logic [2:0] HOP_MASK      = 3'h7;
    localparam logic [7:0] XOR_SEED      = 8'hFF;

    // Header sizes in bytes, counted from the control byte.
    localparam logic [9:0] HDR_STANDARD  = 10'd6;
    localparam logic [9:0] HDR_EXTENDED  = 10'd7;
    localparam logic [9:0] MIN_FRAME     = 10'd7;
    localparam logic [9:0] MIN_EXT_FRAME = 10'd9;
    localparam logic [8:0] POS_MAX       = 9'd511;

    // Result kinds, carried in tuser.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FORMAT   = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

    // Header bytes captured during one frame.
    typedef struct packed {
        logic [7:0]  control_byte;
        logic [7:0]  extension_byte;
        logic [15:0] source_reg;
        logic [15:0] destination_reg;
        logic [7:0]  length_byte;
    } t_hdr;

    // Decoded end-of-frame summary.
    typedef struct packed {
        logic [1:0]  status;
        logic        standard_frame;
        logic        repeated;
        logic [1:0]  priority_res;
        logic [1:0]  service_flags;
        logic        group_destination;
        logic [2:0]  hop_count;
        logic [15:0] source_address;
        logic [15:0] destination_address;
        logic [8:0]  payload_length;
    } t_summary;

endpackage

>>> sv/tp1_frame_decoder_top.sv
// Top level of the TP1 frame decoder: byte stream in, payload and summary stream out.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   tvalid / tready         tdata: rx_byte; tlast: frame_end
//  m_axis    out  tvalid / tready         tuser: kind; tdata: data_byte and summary fields
//
// Each byte is decoded in the cycle it transfers and its result, if any, is
// registered, so a byte can transfer in every cycle at one byte per clock while the sink takes the results.
// Results appear in the cycle after the byte that causes them.
// Synchronous active-low reset clears the frame state and the output valid.
// s_axis_tready is low only while a result is held and the sink stalls.
module tp1_frame_decoder_top
    import tp1fd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status,
                                        // [10] standard_frame, [11] repeated,
                                        // [13:12] priority_res, [15:14] service_flags,
                                        // [16] group_destination, [19:17] hop_count,
                                        // [35:20] source_address,
                                        // [51:36] destination_address,
                                        // [60:52] payload_length, [63:61] zero
    output logic [0:0]  m_axis_tuser    // [0] kind
);

    logic [8:0]  r_pos,   n_pos;
    logic [7:0]  r_xor,   n_xor;
    t_hdr        r_hdr,   n_hdr;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_data,  n_out_data;
    logic        r_out_kind,  n_out_kind;

    logic        accept;
    logic        ext;
    logic [9:0]  hdr_len;
    logic [9:0]  offset;
    t_summary    sum;

    tp1fd_summary #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_summary (
        .i_hdr (r_hdr),
        .i_pos (r_pos),
        .i_xor (r_xor ^ s_axis_tdata),
        .o_sum (sum)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_hdr       = r_hdr;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;

        // The frame format comes from the control byte, which is the byte
        // itself when it is the first of the frame.
        if (r_pos == 9'd0) begin
            ext = (s_axis_tdata & CTRL_STANDARD) == 8'h00;
        end else begin
            ext = (r_hdr.control_byte & CTRL_STANDARD) == 8'h00;
        end
        hdr_len = ext ? HDR_EXTENDED : HDR_STANDARD;
        offset  = {1'b0, r_pos} - hdr_len;

        if (accept) begin
            n_xor = r_xor ^ s_axis_tdata;
            if (!s_axis_tlast) begin
                if (r_pos == 9'd0) begin
                    n_hdr.control_byte = s_axis_tdata;
                end else if (ext) begin
                    case (r_pos)
                        9'd1:       n_hdr.extension_byte = s_axis_tdata;
                        9'd2, 9'd3: n_hdr.source_reg = {r_hdr.source_reg[7:0], s_axis_tdata};
                        9'd4, 9'd5: n_hdr.destination_reg =
                                        {r_hdr.destination_reg[7:0], s_axis_tdata};
                        9'd6:       n_hdr.length_byte = s_axis_tdata;
                        default:    ;
                    endcase
                end else begin
                    case (r_pos)
                        9'd1, 9'd2: n_hdr.source_reg = {r_hdr.source_reg[7:0], s_axis_tdata};
                        9'd3, 9'd4: n_hdr.destination_reg =
                                        {r_hdr.destination_reg[7:0], s_axis_tdata};
                        9'd5:       n_hdr.length_byte = s_axis_tdata;
                        default:    ;
                    endcase
                end

                // Payload bytes beyond the configured maximum are dropped.
                if ({1'b0, r_pos} >= hdr_len && offset < 10'(MAX_PAYLOAD)) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_PAYLOAD;
                    n_out_data  = {56'd0, s_axis_tdata};
                end

                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 9'd1;
                end
            end else begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_SUMMARY;
                n_out_data  = {3'b000, sum.payload_length, sum.destination_address,
                               sum.source_address, sum.hop_count, sum.group_destination,
                               sum.service_flags, sum.priority_res, sum.repeated,
                               sum.standard_frame, sum.status, 8'h00};
                n_pos = 9'd0;
                n_xor = XOR_SEED;
                n_hdr = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 9'd0;
            r_xor       <= XOR_SEED;
            r_hdr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_xor       <= n_xor;
            r_hdr       <= n_hdr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_kind <= n_out_kind;
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_kind;

endmodule

>>> sv/tp1fd_summary.sv
// End-of-frame header decode and status checks.
module tp1fd_summary
    import tp1fd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
) (
    input  t_hdr       i_hdr,
    input  logic [8:0] i_pos,      // position of the check byte
    input  logic [7:0] i_xor,      // running XOR including the check byte
    output t_summary   o_sum
);

    logic       stdf;
    logic [8:0] plen;
    logic [9:0] size;
    logic [9:0] expected;
    logic [7:0] grp_src;

    always_comb begin
        stdf    = (i_hdr.control_byte & CTRL_STANDARD) != 8'h00;
        size    = {1'b0, i_pos} + 10'd1;
        grp_src = stdf ? i_hdr.length_byte : i_hdr.extension_byte;
        if (stdf) begin
            plen = {1'b0, i_hdr.length_byte & NIBBLE_MASK} + 9'd1;
        end else begin
            plen = {1'b0, i_hdr.length_byte} + 9'd1;
        end
        expected = (stdf ? HDR_STANDARD : HDR_EXTENDED) + {1'b0, plen} + 10'd1;

        // Checks are prioritized; the first one that fails sets the status.
        if (size < MIN_FRAME) begin
            o_sum.status = STATUS_FORMAT;
        end else if (i_xor != 8'h00) begin
            o_sum.status = STATUS_CHECKSUM;
        end else if ((i_hdr.control_byte & CTRL_RESERVED) != 8'h00) begin
            o_sum.status = STATUS_FORMAT;
        end else if (!stdf && size < MIN_EXT_FRAME) begin
            o_sum.status = STATUS_FORMAT;
        end else if (!stdf && (i_hdr.extension_byte & NIBBLE_MASK) != 8'h00) begin
            o_sum.status = STATUS_FORMAT;
        end else if (size != expected) begin
            o_sum.status = STATUS_FORMAT;
        end else if ({1'b0, plen} > 10'(MAX_PAYLOAD)) begin
            o_sum.status = STATUS_FORMAT;
        end else begin
            o_sum.status = STATUS_OK;
        end

        o_sum.standard_frame      = stdf;
        o_sum.repeated            = (i_hdr.control_byte & CTRL_REPEAT) == 8'h00;
        o_sum.priority_res        = i_hdr.control_byte[3:2];
        o_sum.service_flags       = i_hdr.control_byte[1:0];
        o_sum.group_destination   = grp_src[7];
        o_sum.hop_count           = grp_src[6:4] & HOP_MASK;
        o_sum.source_address      = i_hdr.source_reg;
        o_sum.destination_address = i_hdr.destination_reg;
        o_sum.payload_length      = plen;
    end

endmodule
